// ----- hw/rtl/drtfl_pkg.sv -----
// Package for the dated rate table: constants, item types and date helpers.
// Used by every module of the dated rate table block.
`default_nettype none
package drtfl_pkg;
   localparam int TableDepth = 4096;
   localparam int AddrW = $clog2(TableDepth);
   localparam int CountW = AddrW + 1;
   localparam int MinYear = 1900;
   localparam int KeyW = 28;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0, ST_UPDATED = 3'd1, ST_BAD_DATE = 3'd2, ST_FULL = 3'd3,
      ST_EXACT = 3'd4, ST_EARLIER = 3'd5, ST_NOT_FOUND = 3'd6
   } status_type;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      logic        lookup;
      logic        valid_date;
      logic [KeyW-1:0] key;
      logic [63:0] value;
   } item_type;

   // Ordering key with month and day at full input width.
   function automatic logic [KeyW-1:0] wide_key(logic [13:0] y, logic [6:0] m, logic [6:0] d);
      return {y, m, d};
   endfunction

   // Gregorian leap year test. The year over 100 comes from a reciprocal
   // multiplication, which is exact for every 14-bit year.
   function automatic logic leap_year(logic [13:0] y);
      logic [26:0] prod;
      logic [7:0]  quo;
      logic [14:0] back;
      logic        div4, div100, div400;
      prod   = y * 13'd5243;
      quo    = prod[26:19];
      back   = quo * 7'd100;
      div4   = (y[1:0] == 2'd0);
      div100 = (back == {1'b0, y});
      div400 = div100 && (quo[1:0] == 2'd0);
      return div4 && (!div100 || div400);
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/drtfl_front.sv -----
// Front part: accepts request transfers, checks the date and queues items.
// Depends on drtfl_pkg.
`default_nettype none
module drtfl_front import drtfl_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire logic     command,
   input  wire logic [13:0] year,
   input  wire logic [6:0]  month,
   input  wire logic [6:0]  day,
   input  wire logic [63:0] value,
   output logic          q_valid,
   input  wire logic     q_pop,
   output item_type      q_item
);
   item_type   slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   item_type   cls;
   logic [4:0] limit;
   logic       push;

   // Day limit for the month.
   always_comb begin
      case (month)
         7'd2: limit = leap_year(year) ? 5'd29 : 5'd28;
         7'd4, 7'd6, 7'd9, 7'd11: limit = 5'd30;
         default: limit = 5'd31;
      endcase
   end

   // Classify the incoming item.
   always_comb begin
      cls.lookup = (command == CMD_LOOKUP);
      cls.valid_date = (year >= 14'(MinYear)) && (month >= 7'd1) && (month <= 7'd12)
                    && (day >= 7'd1) && (day <= {2'b00, limit});
      cls.key = wide_key(year, month, day);
      cls.value = value;
   end

   // Two-entry queue between the front and back parts.
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = slot_ff[rd_ff];
   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (push) slot_ff[wr_ff] <= cls;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/drtfl_back.sv -----
// Back part: binary search, entry shift on insert and result register.
// Depends on drtfl_pkg; holds the key and value memories.
`default_nettype none
module drtfl_back import drtfl_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   output logic          q_pop,
   input  wire item_type q_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output logic [95:0]   out_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_CMP, S_CHK, S_PRV, S_SHRD, S_SHWR, S_FIN, S_OUT
   } state_type;

   logic [22:0] key_mem [TableDepth];
   logic [63:0] val_mem [TableDepth];
   logic [22:0] kq_ff;
   logic [63:0] vq_ff;

   state_type         state_ff;
   item_type          it_ff;
   logic [CountW-1:0] cnt_ff, lo_ff, hi_ff, pos_ff, sh_ff;
   logic [CountW-1:0] mid;
   logic [KeyW-1:0]   kwide;
   logic              match;
   logic [92:0]       found;
   logic [95:0]       res_ff, rsp_ff;
   logic              rsp_v_ff;
   logic              load_out;
   logic              re, we, wkey_en;
   logic [AddrW-1:0]  raddr, waddr;
   logic [22:0]       wkey;
   logic [63:0]       wval;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign kwide = {kq_ff[22:9], 3'b000, kq_ff[8:5], 2'b00, kq_ff[4:0]};
   assign match = (pos_ff < cnt_ff) && (kwide == it_ff.key);
   assign found = {6'd0, vq_ff, kq_ff[4:0], kq_ff[8:5], kq_ff[22:9]};
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign load_out = (state_ff == S_OUT) && (!rsp_v_ff || out_ready);
   assign out_valid = rsp_v_ff;
   assign out_data = rsp_ff;

   // Memory read address per state.
   always_comb begin
      re = 1'b1;
      raddr = mid[AddrW-1:0];
      case (state_ff)
         S_SRCH: raddr = (lo_ff < hi_ff) ? mid[AddrW-1:0] : lo_ff[AddrW-1:0];
         S_CHK:  raddr = pos_ff[AddrW-1:0] - 1'b1;
         S_SHRD: raddr = sh_ff[AddrW-1:0] - 1'b1;
         default: re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (re) begin
         kq_ff <= key_mem[raddr];
         vq_ff <= val_mem[raddr];
      end
      if (we) begin
         val_mem[waddr] <= wval;
         if (wkey_en) key_mem[waddr] <= wkey;
      end
   end

   // Memory write port.
   always_comb begin
      we = 1'b0;
      wkey_en = 1'b1;
      waddr = sh_ff[AddrW-1:0];
      wkey = kq_ff;
      wval = vq_ff;
      case (state_ff)
         S_SHWR: we = 1'b1;
         S_FIN: begin
            we = 1'b1;
            waddr = pos_ff[AddrW-1:0];
            wkey = {it_ff.key[27:14], it_ff.key[10:7], it_ff.key[4:0]};
            wval = it_ff.value;
            wkey_en = (res_ff[2:0] == ST_INSERTED);
         end
         default: we = 1'b0;
      endcase
   end

   // Sequencer: search, decide, shift, then hand the result to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_v_ff <= 1'b1;
            rsp_ff <= res_ff;
         end else if (out_ready) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: if (q_pop) begin
               it_ff <= q_item;
               lo_ff <= '0;
               hi_ff <= cnt_ff;
               state_ff <= S_SRCH;
            end
            S_SRCH: if (lo_ff < hi_ff) begin
               state_ff <= S_CMP;
            end else begin
               pos_ff <= lo_ff;
               state_ff <= S_CHK;
            end
            S_CMP: begin
               if (kwide < it_ff.key) lo_ff <= mid + 1'b1;
               else hi_ff <= mid;
               state_ff <= S_SRCH;
            end
            S_CHK: begin
               // kq_ff holds the entry at the search position.
               if (it_ff.lookup) begin
                  if (match) begin
                     res_ff <= {found, ST_EXACT};
                     state_ff <= S_OUT;
                  end else if (pos_ff != '0) begin
                     state_ff <= S_PRV;
                  end else begin
                     res_ff <= {93'd0, ST_NOT_FOUND};
                     state_ff <= S_OUT;
                  end
               end else if (!it_ff.valid_date) begin
                  res_ff <= {93'd0, ST_BAD_DATE};
                  state_ff <= S_OUT;
               end else if (match) begin
                  res_ff <= {93'd0, ST_UPDATED};
                  state_ff <= S_FIN;
               end else if (cnt_ff >= CountW'(TableDepth)) begin
                  res_ff <= {93'd0, ST_FULL};
                  state_ff <= S_OUT;
               end else begin
                  res_ff <= {93'd0, ST_INSERTED};
                  sh_ff <= cnt_ff;
                  state_ff <= (pos_ff == cnt_ff) ? S_FIN : S_SHRD;
               end
            end
            S_PRV: begin
               // kq_ff holds the entry just before the search position.
               res_ff <= {found, ST_EARLIER};
               state_ff <= S_OUT;
            end
            S_SHRD: state_ff <= S_SHWR;
            S_SHWR: begin
               // Entry sh-1 has been read; it is written to sh this cycle.
               sh_ff <= sh_ff - 1'b1;
               state_ff <= (sh_ff - 1'b1 == pos_ff) ? S_FIN : S_SHRD;
            end
            S_FIN: begin
               if (res_ff[2:0] == ST_INSERTED) cnt_ff <= cnt_ff + 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: if (load_out) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/dated_rate_table_floor_lookup.sv -----
// Table of dated values kept in date order, with insert and floor lookup. A request carries
// a command in req_tuser and a date and value in req_tdata; each request gives exactly one
// response. Each request runs a binary search over the registered key memory, with at most
// 13 probes for 4096 entries. A lookup that falls back to an earlier date reads one more
// entry, an update or an insert ends with a write, and an insert of a new date first moves
// every later entry up, one entry at a time, as there is one memory port.
// A two-entry queue lets requests be taken while the back part is busy, and the output
// register lets the back part start the next item while a response waits.
// Depends on drtfl_pkg, drtfl_front and drtfl_back.
`default_nettype none
module dated_rate_table_floor_lookup import drtfl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,  // year, month, day, value from bit 0; zero fill
   input  wire logic        req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata   // status, found_year, found_month, found_day,
                                        // found_value from bit 0; zero fill
);
   logic     q_valid, q_pop;
   item_type q_item;

   drtfl_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .command(req_tuser), .year(req_tdata[13:0]), .month(req_tdata[20:14]),
      .day(req_tdata[27:21]), .value(req_tdata[91:28]),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   drtfl_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for dated_rate_table_floor_lookup: a directed table, then random traffic.
// Depends on drtfl_pkg and the dated_rate_table_floor_lookup RTL; needs no other files.
`default_nettype none
module tb;
   import drtfl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 60000;
   localparam int RandomItems = 400;

   // One expected response transfer, fields as they leave the block.
   typedef struct {
      status_type  status;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [63:0] value;
   } rate_answer_type;

   // One directed row; typed rows carry their own expected answer.
   typedef struct {
      logic        cmd;
      int          year;
      int          month;
      int          day;
      logic [63:0] value;
      logic        typed;
      status_type  status;
   } dated_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_word = '0;  // year, month, day, value from bit 0 up; zero fill
   logic req_tuser = 1'b0;      // command
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;      // status, found_year, found_month, found_day, found_value

   // Shadow copy of the table, kept sorted by date.
   logic [13:0] shadow_year[TableDepth];
   logic [3:0]  shadow_month[TableDepth];
   logic [4:0]  shadow_day[TableDepth];
   logic [63:0] shadow_value[TableDepth];
   int          shadow_count = 0;

   rate_answer_type pending_answers[$];
   int  failures = 0;
   int  answers_seen = 0;
   int  idle_cycles = 0;
   bit  calm_stretch = 1'b0;
   int  hits_seen = 0;
   int  full_seen = 0;

   dated_rate_table_floor_lookup uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_word), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [27:0] shadow_key(int idx);
      return {shadow_year[idx], 3'b000, shadow_month[idx], 2'b00, shadow_day[idx]};
   endfunction

   function automatic bit gregorian_ok(int y, int m, int d);
      int limit;
      if (y < MinYear || m < 1 || m > 12 || d < 1) return 1'b0;
      if (m == 2)
         limit = ((y % 4 == 0) && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
      else if (m == 4 || m == 6 || m == 9 || m == 11)
         limit = 30;
      else
         limit = 31;
      return d <= limit;
   endfunction

   // Applies one command to the shadow table and returns the answer it gives.
   function automatic rate_answer_type table_answer(logic cmd, int y, int m, int d,
                                                    logic [63:0] v);
      rate_answer_type ans;
      logic [27:0] probe;
      int lo, hi, mid, hit;
      bit same;
      ans = '{ST_INSERTED, '0, '0, '0, '0};
      probe = {y[13:0], m[6:0], d[6:0]};
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (shadow_key(mid) < probe) lo = mid + 1;
         else hi = mid;
      end
      same = (lo < shadow_count) && (shadow_key(lo) == probe);
      if (cmd == CMD_INSERT) begin
         if (!gregorian_ok(y, m, d)) begin
            ans.status = ST_BAD_DATE;
         end else if (same) begin
            shadow_value[lo] = v;
            ans.status = ST_UPDATED;
         end else if (shadow_count >= TableDepth) begin
            ans.status = ST_FULL;
         end else begin
            for (int i = shadow_count; i > lo; i--) begin
               shadow_year[i] = shadow_year[i-1];
               shadow_month[i] = shadow_month[i-1];
               shadow_day[i] = shadow_day[i-1];
               shadow_value[i] = shadow_value[i-1];
            end
            shadow_year[lo] = y[13:0];
            shadow_month[lo] = m[3:0];
            shadow_day[lo] = d[4:0];
            shadow_value[lo] = v;
            shadow_count++;
            ans.status = ST_INSERTED;
         end
      end else begin
         hit = lo;
         if (same) ans.status = ST_EXACT;
         else if (lo > 0) begin
            hit = lo - 1;
            ans.status = ST_EARLIER;
         end else ans.status = ST_NOT_FOUND;
         if (ans.status != ST_NOT_FOUND) begin
            ans.year = shadow_year[hit];
            ans.month = shadow_month[hit];
            ans.day = shadow_day[hit];
            ans.value = shadow_value[hit];
         end
      end
      return ans;
   endfunction

   // Sends one request transfer, with an optional gap, and records its answer.
   task automatic send_request(logic cmd, int y, int m, int d, logic [63:0] v,
                               logic typed, status_type typed_status);
      rate_answer_type ans;
      @(negedge clock);
      if (!calm_stretch) begin
         while ($urandom_range(99) < 25) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_word <= {4'b0, v, d[6:0], m[6:0], y[13:0]};
      do @(posedge clock); while (!req_tready);
      ans = table_answer(cmd, y, m, d, v);
      // Typed rows are plain enough to read off the date rules directly.
      if (typed) ans = '{typed_status, '0, '0, '0, '0};
      pending_answers.push_back(ans);
   endtask

   // Response side: random backpressure, outside the calm stretch.
   always @(negedge clock)
      rsp_tready <= calm_stretch ? 1'b1 : ($urandom_range(99) >= 25);

   // Response checking and the watchdog.
   always @(posedge clock) begin
      rate_answer_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
            $display("FAILURE");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               failures++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tdata[2:0] != want.status || rsp_tdata[16:3] != want.year ||
                   rsp_tdata[20:17] != want.month || rsp_tdata[25:21] != want.day ||
                   rsp_tdata[89:26] != want.value || rsp_tdata[95:90] != '0) begin
                  $display("%0t: expected st=%0d %0d-%0d-%0d v=%h, got st=%0d %0d-%0d-%0d v=%h",
                           $time, want.status, want.year, want.month, want.day, want.value,
                           rsp_tdata[2:0], rsp_tdata[16:3], rsp_tdata[20:17],
                           rsp_tdata[25:21], rsp_tdata[89:26]);
                  failures++;
               end
               if (want.status inside {ST_EXACT, ST_EARLIER}) hits_seen++;
               if (want.status == ST_FULL) full_seen++;
            end
         end
      end
   end

   dated_row_type directed_rows[] = '{
      '{CMD_LOOKUP, 2000, 1, 1, 64'd0, 1'b1, ST_NOT_FOUND},
      '{CMD_INSERT, 1899, 12, 31, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2001, 0, 5, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2001, 13, 5, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2001, 5, 0, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 1900, 2, 29, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2000, 2, 30, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2001, 4, 31, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2023, 2, 29, 64'd1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 9999, 99, 99, '1, 1'b1, ST_BAD_DATE},
      '{CMD_INSERT, 2000, 2, 29, 64'h8000_0000_0000_0000, 1'b1, ST_INSERTED},
      '{CMD_INSERT, 1900, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ST_INSERTED},
      '{CMD_INSERT, 9999, 12, 31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_INSERTED},
      '{CMD_INSERT, 2024, 1, 31, 64'h0000_0001_8000_0000, 1'b1, ST_INSERTED},
      '{CMD_INSERT, 2000, 2, 29, 64'h1234_5678_9ABC_DEF0, 1'b1, ST_UPDATED},
      '{CMD_LOOKUP, 2000, 2, 29, 64'd0, 1'b0, ST_EXACT},
      '{CMD_LOOKUP, 2010, 6, 15, 64'd0, 1'b0, ST_EARLIER},
      '{CMD_LOOKUP, 1899, 12, 31, 64'd0, 1'b1, ST_NOT_FOUND},
      '{CMD_LOOKUP, 0, 0, 0, 64'd0, 1'b1, ST_NOT_FOUND},
      '{CMD_LOOKUP, 2000, 99, 99, 64'd0, 1'b0, ST_EARLIER},
      '{CMD_LOOKUP, 9999, 99, 99, 64'd0, 1'b0, ST_EARLIER},
      '{CMD_LOOKUP, 1900, 1, 1, 64'd0, 1'b0, ST_EXACT},
      '{CMD_LOOKUP, 9999, 12, 31, 64'd0, 1'b0, ST_EXACT}
   };

   initial begin
      int y, m, d, pick;
      logic [63:0] v;
      logic cmd;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      foreach (directed_rows[i])
         send_request(directed_rows[i].cmd, directed_rows[i].year, directed_rows[i].month,
                      directed_rows[i].day, directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].status);

      // Hold off until every answer is back before the random traffic.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);

      // Random traffic: mostly valid dates in a few busy years so lookups hit.
      for (int n = 0; n < RandomItems; n++) begin
         calm_stretch = (n >= 150 && n < 210);
         v = {$urandom, $urandom};
         cmd = $urandom_range(1);
         pick = $urandom_range(99);
         if (pick < 80) begin
            y = $urandom_range(2003, 1998);
            m = $urandom_range(12, 1);
            d = $urandom_range(31, 1);
         end else if (pick < 90) begin
            y = $urandom_range(9999);
            m = $urandom_range(99);
            d = $urandom_range(99);
         end else begin
            y = $urandom_range(1) ? 1900 : 9999;
            m = $urandom_range(12, 1);
            d = $urandom_range(31, 28);
         end
         send_request(cmd, y, m, d, v, 1'b0, ST_INSERTED);
      end
      calm_stretch = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d answers, %0d of them lookups that found an entry.",
               answers_seen, hits_seen);
      $display("Inserts refused by a full table: %0d.", full_seen);
      if (failures == 0 && pending_answers.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
